>>> design/dpjq_pkg.sv
// package for the dedup priority job queue
// status codes, op codes, register index and default sizes; no dependencies
package dpjq_pkg;
  localparam int unsigned QueueDepthDef  = 16;
  localparam int unsigned CancelDepthDef = 16;
  localparam int unsigned KeyBitsDef     = 32;
  localparam int unsigned MaxJobsReset   = 16;

  localparam logic [1:0] MaxJobsAddr = 2'd0;

  localparam logic [1:0] OpSchedule   = 2'd0;
  localparam logic [1:0] OpTakeNext   = 2'd1;
  localparam logic [1:0] OpTakeCancel = 2'd2;

  localparam logic [2:0] StScheduled = 3'd0;
  localparam logic [2:0] StDupUpdate = 3'd1;
  localparam logic [2:0] StRejected  = 3'd2;
  localparam logic [2:0] StReturned  = 3'd3;
  localparam logic [2:0] StNone      = 3'd4;
  localparam logic [2:0] StEvicted   = 3'd5;
endpackage

>>> design/dedup_priority_job_queue_unit.sv
// top level of the dedup priority job queue
// depends on dpjq_pkg and dpjq_list
// one sequencer steps through the two list memories entry by entry: a read state, then a check state that may write
// one item at a time; the input is not ready until the result has been taken
// reset: counts cleared, max_jobs to 16, list contents undefined until written
module dedup_priority_job_queue_unit import dpjq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH  = QueueDepthDef,
  parameter int unsigned CANCEL_DEPTH = CancelDepthDef,
  parameter int unsigned KEY_BITS     = KeyBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] job_key_i,
  input  logic        job_empty_i,
  input  logic [7:0]  priority_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] out_key_o,
  output logic [31:0] evicted_key_o,
  output logic        has_scheduled_o,
  output logic        has_cancelled_o,
  output logic        cancel_overflow_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CAW = (CANCEL_DEPTH > 1) ? $clog2(CANCEL_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CCW = $clog2(CANCEL_DEPTH + 1);
  localparam int unsigned SW  = KEY_BITS + 8;
  localparam int unsigned KOW = (KEY_BITS < 32) ? KEY_BITS : 32;

  typedef enum logic [3:0] {
    StIdle, StQRd, StQChk, StSchedDec, StEvRd, StEvChk, StCPush, StCRd, StCChk,
    StAppend, StCSrch, StCSrchChk, StMinRd, StMinChk, StOut
  } state_e;

  state_e           state_q;
  logic [4:0]       max_jobs_q;
  logic [QCW-1:0]   qcnt_q;
  logic [CCW-1:0]   ccnt_q;
  logic [1:0]       op_q;
  logic [KEY_BITS-1:0] key_q, ekey_q, okey_q;
  logic [7:0]       prio_q, best_prio_q;
  logic [QCW-1:0]   idx_q;       // walk index, scheduled list
  logic [CCW-1:0]   cidx_q;      // walk index, cancelled list
  logic [QCW-1:0]   best_q;
  logic             compact_q;   // walk is shifting entries down
  logic [2:0]       status_q;
  logic             ovf_q;
  logic [QCW-1:0]   lim;

  // scheduled list memory
  logic             q_we;
  logic [QAW-1:0]   q_waddr, q_raddr;
  logic [SW-1:0]    q_wdata, q_rdata;
  // cancelled list memory
  logic             c_we;
  logic [CAW-1:0]   c_waddr, c_raddr;
  logic [KEY_BITS-1:0] c_wdata, c_rdata;

  function automatic logic priority_req_lt(input logic [7:0] a, input logic [7:0] b);
    priority_req_lt = (a < b);
  endfunction

  dpjq_list #(.Depth(QUEUE_DEPTH), .DataW(SW)) u_sched (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );
  dpjq_list #(.Depth(CANCEL_DEPTH), .DataW(KEY_BITS)) u_cancel (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .raddr_i(c_raddr), .rdata_o(c_rdata)
  );

  // effective limit: zero acts as one, clipped to the depth
  always_comb begin
    if (max_jobs_q == 5'd0) begin
      lim = QCW'(1);
    end else if (32'(max_jobs_q) > QUEUE_DEPTH) begin
      lim = QCW'(QUEUE_DEPTH);
    end else begin
      lim = QCW'(max_jobs_q);
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == MaxJobsAddr) ? {27'd0, max_jobs_q} : 32'd0;
  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign status_o = status_q;
  assign out_key_o = 32'(okey_q[KOW-1:0]);
  assign evicted_key_o = 32'(ekey_q[KOW-1:0]);
  assign has_scheduled_o = (qcnt_q != '0);
  assign has_cancelled_o = (ccnt_q != '0);
  assign cancel_overflow_o = ovf_q;

  // memory addressing: walks read idx, compaction writes idx-1
  always_comb begin
    q_raddr = idx_q[QAW-1:0];
    c_raddr = cidx_q[CAW-1:0];
    q_we = 1'b0;
    q_waddr = idx_q[QAW-1:0];
    q_wdata = q_rdata;
    c_we = 1'b0;
    c_waddr = cidx_q[CAW-1:0];
    c_wdata = c_rdata;
    case (state_q)
      StQChk: begin
        // duplicate found: lower priority in place
        if (q_rdata[SW-1:8] == key_q && priority_req_lt(prio_q, q_rdata[7:0])) begin
          q_we = 1'b1;
          q_wdata = {key_q, prio_q};
        end
      end
      StEvChk, StMinChk: begin
        if (compact_q) begin
          q_we = 1'b1;
          q_waddr = QAW'(idx_q - QCW'(1));
        end
      end
      StCChk, StCSrchChk: begin
        if (compact_q) begin
          c_we = 1'b1;
          c_waddr = CAW'(cidx_q - CCW'(1));
        end
      end
      StCPush: begin
        c_we = 1'b1;
        c_waddr = cidx_q[CAW-1:0];
        c_wdata = ekey_q;
      end
      StAppend: begin
        q_we = (qcnt_q < QCW'(QUEUE_DEPTH));
        q_waddr = qcnt_q[QAW-1:0];
        q_wdata = {key_q, prio_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      max_jobs_q <= 5'(MaxJobsReset);
      qcnt_q <= '0;
      ccnt_q <= '0;
      op_q <= '0;
      key_q <= '0;
      ekey_q <= '0;
      okey_q <= '0;
      prio_q <= '0;
      best_prio_q <= '0;
      idx_q <= '0;
      cidx_q <= '0;
      best_q <= '0;
      compact_q <= 1'b0;
      status_q <= StNone;
      ovf_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == MaxJobsAddr) begin
        max_jobs_q <= pwdata[4:0];
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            op_q <= op_i;
            key_q <= KEY_BITS'(job_key_i);
            prio_q <= priority_req_i;
            ekey_q <= '0;
            okey_q <= '0;
            ovf_q <= 1'b0;
            idx_q <= '0;
            cidx_q <= '0;
            compact_q <= 1'b0;
            status_q <= StNone;
            case (op_i)
              OpSchedule: begin
                if (job_empty_i) begin
                  status_q <= StRejected;
                  state_q <= StOut;
                end else if (qcnt_q == '0) begin
                  state_q <= StSchedDec;
                end else begin
                  state_q <= StQRd;
                end
              end
              OpTakeNext: begin
                if (qcnt_q != '0) begin
                  state_q <= StMinRd;
                  best_q <= '0;
                  best_prio_q <= 8'hff;
                end else begin
                  state_q <= StOut;
                end
              end
              OpTakeCancel: begin
                // pop head: compact from entry 1
                if (ccnt_q != '0) begin
                  state_q <= StCRd;
                end else begin
                  state_q <= StOut;
                end
              end
              default: state_q <= StOut;
            endcase
          end
        end
        // duplicate search over the scheduled list
        StQRd: state_q <= StQChk;
        StQChk: begin
          if (q_rdata[SW-1:8] == key_q) begin
            status_q <= StDupUpdate;
            state_q <= StOut;
          end else if (idx_q + QCW'(1) >= qcnt_q) begin
            state_q <= StSchedDec;
          end else begin
            idx_q <= idx_q + QCW'(1);
            state_q <= StQRd;
          end
        end
        StSchedDec: begin
          if (qcnt_q >= lim) begin
            status_q <= StEvicted;
            idx_q <= '0;
            compact_q <= 1'b0;
            state_q <= StEvRd;
          end else begin
            status_q <= StScheduled;
            state_q <= StAppend;
          end
        end
        // eviction: read head, then shift the rest down
        StEvRd: state_q <= StEvChk;
        StEvChk: begin
          if (!compact_q) begin
            ekey_q <= q_rdata[SW-1:8];
          end
          if (idx_q + QCW'(1) >= qcnt_q) begin
            qcnt_q <= qcnt_q - QCW'(1);
            // cancelled push: drop head when full
            if (ccnt_q >= CCW'(CANCEL_DEPTH)) begin
              ovf_q <= 1'b1;
              cidx_q <= CCW'(1);
              compact_q <= 1'b1;
              state_q <= (CANCEL_DEPTH > 1) ? StCRd : StCPush;
              if (CANCEL_DEPTH <= 1) begin
                ccnt_q <= ccnt_q - CCW'(1);
                cidx_q <= '0;
              end
            end else begin
              cidx_q <= ccnt_q;
              state_q <= StCPush;
            end
          end else begin
            idx_q <= idx_q + QCW'(1);
            compact_q <= 1'b1;
            state_q <= StEvRd;
          end
        end
        // cancelled head removal, shared by overflow drop and take-cancelled
        StCRd: begin
          if (cidx_q >= ccnt_q) begin
            ccnt_q <= ccnt_q - CCW'(1);
            if (op_q == OpSchedule) begin
              cidx_q <= ccnt_q - CCW'(1);
              state_q <= StCPush;
            end else begin
              status_q <= StReturned;
              state_q <= StOut;
            end
          end else begin
            state_q <= StCChk;
          end
        end
        StCChk: begin
          if (!compact_q) begin
            okey_q <= c_rdata;
            compact_q <= 1'b1;
          end
          cidx_q <= cidx_q + CCW'(1);
          state_q <= StCRd;
        end
        StCPush: begin
          ccnt_q <= ccnt_q + CCW'(1);
          state_q <= StAppend;
        end
        StAppend: begin
          if (qcnt_q < QCW'(QUEUE_DEPTH)) begin
            qcnt_q <= qcnt_q + QCW'(1);
          end
          cidx_q <= '0;
          compact_q <= 1'b0;
          state_q <= (ccnt_q != '0) ? StCSrch : StOut;
        end
        // remove the new key from the cancelled list if present
        StCSrch: begin
          if (cidx_q >= ccnt_q) begin
            if (compact_q) begin
              ccnt_q <= ccnt_q - CCW'(1);
            end
            state_q <= StOut;
          end else begin
            state_q <= StCSrchChk;
          end
        end
        StCSrchChk: begin
          if (!compact_q && c_rdata == key_q) begin
            compact_q <= 1'b1;
          end
          cidx_q <= cidx_q + CCW'(1);
          state_q <= StCSrch;
        end
        // take-next: first pass finds the minimum, second compacts past it
        StMinRd: begin
          if (idx_q >= qcnt_q) begin
            if (compact_q) begin
              qcnt_q <= qcnt_q - QCW'(1);
              status_q <= StReturned;
              state_q <= StOut;
            end else begin
              compact_q <= 1'b1;
              idx_q <= best_q + QCW'(1);
            end
          end else begin
            state_q <= StMinChk;
          end
        end
        StMinChk: begin
          if (!compact_q) begin
            if (idx_q == '0 || q_rdata[7:0] < best_prio_q) begin
              best_q <= idx_q;
              best_prio_q <= q_rdata[7:0];
              okey_q <= q_rdata[SW-1:8];
            end
          end
          idx_q <= idx_q + QCW'(1);
          state_q <= StMinRd;
        end
        StOut: begin
          if (out_ready_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

>>> design/dpjq_list.sv
// one ordered list in a memory with a registered read port, searched and compacted entry by entry by the top level
// depends on dpjq_pkg
module dpjq_list import dpjq_pkg::*; #(
  parameter int unsigned Depth = 16,
  parameter int unsigned DataW = 40,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [DataW-1:0] rdata_o
);
  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end
  assign rdata_o = rdata_q;
endmodule
